// File: src/bdp_pkg.sv
`default_nettype none

package bdp_pkg;

    // Field and datapath widths
    localparam int unsigned PixW      = 10;   // pixel_x / pixel_y
    localparam int unsigned CoordW    = 12;   // covers image sizes up to 4096
    localparam int unsigned ChanW     = 8;
    localparam int unsigned NumStages = 11;

    localparam int unsigned DefImageWidth  = 1024;
    localparam int unsigned DefImageHeight = 768;

    // Gradient blend: numerator < 2^20, reciprocal scaled by 2^20
    localparam int unsigned GradNumW   = 20;
    localparam int unsigned GradShift  = 20;
    localparam int unsigned GradRecipW = 21;
    localparam int unsigned GradProdW  = GradNumW + GradRecipW;

    // Glow distance
    localparam int unsigned DeltaW      = 13;
    localparam int unsigned SqW         = 23;
    localparam int unsigned DistShift   = 23;
    localparam int unsigned DistW       = 21;
    localparam int unsigned DistProdW   = 46;
    localparam int unsigned Recip6      = (1 << DistShift) / 6;
    localparam int unsigned Recip3      = (1 << DistShift) / 3;
    localparam int unsigned GlowLimit   = 36000;
    localparam int unsigned GlowFalloff = 450;
    localparam int unsigned FallW       = 16;
    localparam int unsigned FallShift   = 16;
    localparam int unsigned RecipFall   = (1 << FallShift) / GlowFalloff;
    localparam int unsigned GlowPeak    = 80;

    // Fixed-scale blends (divide by 255)
    localparam int unsigned FullScale  = 255;
    localparam int unsigned MixNumW    = 16;
    localparam int unsigned MixShift   = 16;
    localparam int unsigned MixProdW   = 25;
    localparam int unsigned Recip255   = (1 << MixShift) / FullScale;

    // Dither hash
    localparam logic [31:0] HashMulX   = 32'd374761393;
    localparam logic [31:0] HashMulY   = 32'd668265263;
    localparam logic [31:0] HashMulMix = 32'd1274126177;
    localparam int unsigned DitherW    = 3;

    // Register reset values
    localparam logic [23:0] RstCornerTl = 24'h13263b;
    localparam logic [23:0] RstCornerBl = 24'h192844;
    localparam logic [23:0] RstCornerTr = 24'h06101c;
    localparam logic [23:0] RstCornerBr = 24'h142636;
    localparam logic [23:0] RstGlow     = 24'h375f88;

    typedef enum logic [2:0] {
        RegCornerTl = 3'd0,
        RegCornerBl = 3'd1,
        RegCornerTr = 3'd2,
        RegCornerBr = 3'd3,
        RegGlow     = 3'd4
    } reg_idx_t;

    typedef logic [PixW-1:0]   pix_t;
    typedef logic [CoordW-1:0] coord_t;
    typedef logic [ChanW-1:0]  chan_t;
    // index 2 is red, 0 is blue: same layout as the 8:8:8 registers
    typedef chan_t [2:0]       rgb_t;
    // stage enables, indexed by stage number
    typedef logic [NumStages:1] stage_en_t;

    // Fix up a reciprocal quotient that may be one low
    function automatic logic [31:0] div_fix(input logic [31:0] num,
                                            input logic [31:0] quo,
                                            input logic [31:0] den);
        logic [31:0] rem;
        rem = num - quo * den;
        div_fix = (rem >= den) ? quo + 32'd1 : quo;
    endfunction

endpackage

`default_nettype wire

// File: src/bdp_grad.sv
`default_nettype none

// Four-corner gradient, stages 2..7
module bdp_grad import bdp_pkg::*; #(
    parameter int unsigned IMAGE_WIDTH  = DefImageWidth,
    parameter int unsigned IMAGE_HEIGHT = DefImageHeight
) (
    input  wire logic      aclk,
    input  wire stage_en_t stage_en,
    input  wire pix_t      x_in,
    input  wire pix_t      y_in,
    input  wire rgb_t      corner_tl,
    input  wire rgb_t      corner_bl,
    input  wire rgb_t      corner_tr,
    input  wire rgb_t      corner_br,
    output rgb_t           base_out
);

    localparam coord_t HeightLast = CoordW'(IMAGE_HEIGHT - 1);
    localparam coord_t WidthLast  = CoordW'(IMAGE_WIDTH - 1);
    localparam int unsigned RecipH = (1 << GradShift) / (IMAGE_HEIGHT - 1);
    localparam int unsigned RecipW = (1 << GradShift) / (IMAGE_WIDTH - 1);

    typedef logic [GradNumW-1:0]  gnum_t;
    typedef logic [GradProdW-1:0] gprod_t;

    gnum_t  [2:0] num_l2_next, num_r2_next, num_l2_reg, num_r2_reg;
    gprod_t [2:0] prod_l3_next, prod_r3_next, prod_l3_reg, prod_r3_reg;
    gnum_t  [2:0] num_l3_reg, num_r3_reg;
    rgb_t         edge_l4_next, edge_r4_next, edge_l4_reg, edge_r4_reg;
    gnum_t  [2:0] num_c5_next, num_c5_reg;
    gprod_t [2:0] prod_c6_next, prod_c6_reg;
    gnum_t  [2:0] num_c6_reg;
    rgb_t         base7_next, base7_reg;
    pix_t         x2_reg, x3_reg, x4_reg;
    coord_t       ny, nx;

    // stage 2: vertical blend numerators
    always_comb begin
        ny = HeightLast - CoordW'(y_in);
        for (int ch = 0; ch < 3; ch++) begin
            num_l2_next[ch] = GradNumW'(corner_tl[ch]) * GradNumW'(ny)
                            + GradNumW'(corner_bl[ch]) * GradNumW'(y_in);
            num_r2_next[ch] = GradNumW'(corner_tr[ch]) * GradNumW'(ny)
                            + GradNumW'(corner_br[ch]) * GradNumW'(y_in);
        end
    end

    // stage 3: multiply by reciprocal of last row
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod_l3_next[ch] = GradProdW'(num_l2_reg[ch]) * GradProdW'(RecipH);
            prod_r3_next[ch] = GradProdW'(num_r2_reg[ch]) * GradProdW'(RecipH);
        end
    end

    // stage 4: quotient correction gives the edge colors
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            edge_l4_next[ch] = ChanW'(div_fix(32'(num_l3_reg[ch]),
                                              32'(prod_l3_reg[ch][GradShift +: ChanW]),
                                              32'(HeightLast)));
            edge_r4_next[ch] = ChanW'(div_fix(32'(num_r3_reg[ch]),
                                              32'(prod_r3_reg[ch][GradShift +: ChanW]),
                                              32'(HeightLast)));
        end
    end

    // stage 5: horizontal blend numerators
    always_comb begin
        nx = WidthLast - CoordW'(x4_reg);
        for (int ch = 0; ch < 3; ch++) begin
            num_c5_next[ch] = GradNumW'(edge_l4_reg[ch]) * GradNumW'(nx)
                            + GradNumW'(edge_r4_reg[ch]) * GradNumW'(x4_reg);
        end
    end

    // stage 6: multiply by reciprocal of last column
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod_c6_next[ch] = GradProdW'(num_c5_reg[ch]) * GradProdW'(RecipW);
        end
    end

    // stage 7: correction gives the base color
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            base7_next[ch] = ChanW'(div_fix(32'(num_c6_reg[ch]),
                                            32'(prod_c6_reg[ch][GradShift +: ChanW]),
                                            32'(WidthLast)));
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            num_l2_reg <= num_l2_next;
            num_r2_reg <= num_r2_next;
            x2_reg     <= x_in;
        end
        if (stage_en[3]) begin
            prod_l3_reg <= prod_l3_next;
            prod_r3_reg <= prod_r3_next;
            num_l3_reg  <= num_l2_reg;
            num_r3_reg  <= num_r2_reg;
            x3_reg      <= x2_reg;
        end
        if (stage_en[4]) begin
            edge_l4_reg <= edge_l4_next;
            edge_r4_reg <= edge_r4_next;
            x4_reg      <= x3_reg;
        end
        if (stage_en[5]) begin
            num_c5_reg <= num_c5_next;
        end
        if (stage_en[6]) begin
            prod_c6_reg <= prod_c6_next;
            num_c6_reg  <= num_c5_reg;
        end
        if (stage_en[7]) begin
            base7_reg <= base7_next;
        end
    end

    assign base_out = base7_reg;

endmodule

`default_nettype wire

// File: src/bdp_glow.sv
`default_nettype none

// Elliptical glow weight, stages 2..7
module bdp_glow import bdp_pkg::*; #(
    parameter int unsigned IMAGE_WIDTH  = DefImageWidth,
    parameter int unsigned IMAGE_HEIGHT = DefImageHeight
) (
    input  wire logic      aclk,
    input  wire stage_en_t stage_en,
    input  wire pix_t      x_in,
    input  wire pix_t      y_in,
    output chan_t          glow_out
);

    localparam int unsigned CenterX = IMAGE_WIDTH / 2;
    localparam int unsigned CenterY = IMAGE_HEIGHT / 3;

    logic signed [DeltaW-1:0]   dx, dy;
    logic signed [2*DeltaW-1:0] sqx_full, sqy_full;
    logic [SqW-1:0]             sqx2_reg, sqy2_reg, sqx3_reg, sqy3_reg;
    logic [DistProdW-1:0]       px3_next, py3_next, px3_reg, py3_reg;
    logic [DistW-1:0]           qx, qy, dist4_next, dist4_reg;
    logic [FallW-1:0]           dlow5_reg;
    logic [FallW+ChanW-1:0]     pf5_next, pf5_reg;
    logic                       near5_reg;
    logic [ChanW-1:0]           qf;
    chan_t                      glow6_next, glow6_reg, glow7_reg;

    // stage 2: offsets from the glow center, squared
    always_comb begin
        dx = DeltaW'(x_in) - DeltaW'(CenterX);
        dy = DeltaW'(y_in) - DeltaW'(CenterY);
        sqx_full = dx * dx;
        sqy_full = dy * dy;
    end

    // stage 3: reciprocal multiplies for /6 and /3
    always_comb begin
        px3_next = DistProdW'(sqx2_reg) * DistProdW'(Recip6);
        py3_next = DistProdW'(sqy2_reg) * DistProdW'(Recip3);
    end

    // stage 4: corrected quotients, summed
    always_comb begin
        qx = DistW'(div_fix(32'(sqx3_reg), 32'(px3_reg[DistShift +: DistW]), 32'd6));
        qy = DistW'(div_fix(32'(sqy3_reg), 32'(py3_reg[DistShift +: DistW]), 32'd3));
        dist4_next = qx + qy;
    end

    // stage 5: falloff reciprocal multiply
    assign pf5_next = (FallW + ChanW)'(dist4_reg[FallW-1:0])
                    * (FallW + ChanW)'(RecipFall);

    // stage 6: falloff quotient and weight
    always_comb begin
        qf = ChanW'(div_fix(32'(dlow5_reg), 32'(pf5_reg[FallShift +: ChanW]),
                            32'(GlowFalloff)));
        glow6_next = near5_reg ? ChanW'(GlowPeak) - qf : '0;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            sqx2_reg <= sqx_full[SqW-1:0];
            sqy2_reg <= sqy_full[SqW-1:0];
        end
        if (stage_en[3]) begin
            px3_reg  <= px3_next;
            py3_reg  <= py3_next;
            sqx3_reg <= sqx2_reg;
            sqy3_reg <= sqy2_reg;
        end
        if (stage_en[4]) begin
            dist4_reg <= dist4_next;
        end
        if (stage_en[5]) begin
            pf5_reg   <= pf5_next;
            dlow5_reg <= dist4_reg[FallW-1:0];
            near5_reg <= (dist4_reg < DistW'(GlowLimit));
        end
        if (stage_en[6]) begin
            glow6_reg <= glow6_next;
        end
        if (stage_en[7]) begin
            glow7_reg <= glow6_reg;
        end
    end

    assign glow_out = glow7_reg;

endmodule

`default_nettype wire

// File: src/bdp_hash.sv
`default_nettype none

// Coordinate hash for dither weight, stages 2..7
module bdp_hash import bdp_pkg::*; (
    input  wire logic         aclk,
    input  wire stage_en_t    stage_en,
    input  wire pix_t         x_in,
    input  wire pix_t         y_in,
    output logic [DitherW-1:0] dither_out
);

    logic [31:0]        hx2_reg, hy2_reg;
    logic [31:0]        sum3, mix3_next, mix3_reg;
    logic [31:0]        h4_reg;
    logic [DitherW-1:0] w5_next, w5_reg, w6_reg, w7_reg;

    // stage 3: sum and first xor-shift
    always_comb begin
        sum3      = hx2_reg + hy2_reg;
        mix3_next = sum3 ^ (sum3 >> 13);
    end

    // stage 5: low bits of the final xor-shift
    assign w5_next = h4_reg[DitherW-1:0] ^ h4_reg[16 +: DitherW];

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            hx2_reg <= 32'(x_in) * HashMulX;
            hy2_reg <= 32'(y_in) * HashMulY;
        end
        if (stage_en[3]) begin
            mix3_reg <= mix3_next;
        end
        if (stage_en[4]) begin
            h4_reg <= mix3_reg * HashMulMix;
        end
        if (stage_en[5]) begin
            w5_reg <= w5_next;
        end
        if (stage_en[6]) begin
            w6_reg <= w5_reg;
        end
        if (stage_en[7]) begin
            w7_reg <= w6_reg;
        end
    end

    assign dither_out = w7_reg;

endmodule

`default_nettype wire

// File: src/bdp_mix.sv
`default_nettype none

// Glow and dither blends, stages 8..11
module bdp_mix import bdp_pkg::*; (
    input  wire logic               aclk,
    input  wire stage_en_t          stage_en,
    input  wire rgb_t               base_in,
    input  wire chan_t              glow_in,
    input  wire logic [DitherW-1:0] dither_in,
    input  wire rgb_t               glow_color,
    output rgb_t                    pixel_out
);

    typedef logic [MixNumW-1:0] mnum_t;

    mnum_t [2:0]        num8_next, num8_reg, num10_next, num10_reg;
    rgb_t               col9_next, col9_reg, col11_next, col11_reg;
    logic [DitherW-1:0] w8_reg, w9_reg;
    chan_t              ng, nw;

    function automatic chan_t div255(input mnum_t num);
        logic [MixProdW-1:0] prod;
        prod = MixProdW'(num) * MixProdW'(Recip255);
        div255 = ChanW'(div_fix(32'(num), 32'(prod[MixShift +: ChanW]),
                                32'(FullScale)));
    endfunction

    // stage 8: glow blend numerators
    always_comb begin
        ng = ChanW'(FullScale) - glow_in;
        for (int ch = 0; ch < 3; ch++) begin
            num8_next[ch] = MixNumW'(base_in[ch]) * MixNumW'(ng)
                          + MixNumW'(glow_color[ch]) * MixNumW'(glow_in);
        end
    end

    // stage 9: divide by full scale
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            col9_next[ch] = div255(num8_reg[ch]);
        end
    end

    // stage 10: dither toward white
    always_comb begin
        nw = ChanW'(FullScale) - ChanW'(w9_reg);
        for (int ch = 0; ch < 3; ch++) begin
            num10_next[ch] = MixNumW'(col9_reg[ch]) * MixNumW'(nw)
                           + MixNumW'(FullScale) * MixNumW'(w9_reg);
        end
    end

    // stage 11: divide by full scale, output word
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            col11_next[ch] = div255(num10_reg[ch]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[8]) begin
            num8_reg <= num8_next;
            w8_reg   <= dither_in;
        end
        if (stage_en[9]) begin
            col9_reg <= col9_next;
            w9_reg   <= w8_reg;
        end
        if (stage_en[10]) begin
            num10_reg <= num10_next;
        end
        if (stage_en[11]) begin
            col11_reg <= col11_next;
        end
    end

    assign pixel_out = col11_reg;

endmodule

`default_nettype wire

// File: src/procedural_backdrop_pixel.sv
`default_nettype none

// Backdrop pixel generator. Each input word carries one pixel coordinate and
// yields one output word with the pixel's 8-bit red, green and blue. The color
// is a four-corner gradient, plus an elliptical glow centered at half width and
// a third of height, plus a small hash-based dither toward white. Coordinates
// beyond the image saturate to the last column or row. The datapath is an
// 11-stage register pipeline (clamp, gradient with reciprocal-multiply
// division, glow distance, hash, two fixed-scale blends): it takes one pixel
// per clock when the output side is ready, and m_tvalid for a pixel rises once
// it reaches the last stage. A stalled output holds only the stages that are
// full; empty stages keep filling. Corner and glow colors are written through
// the APB port at byte offsets 0x00, 0x04, 0x08, 0x0C and 0x10; the user must
// write them only while the pipeline is empty. The block does not enforce it.
module procedural_backdrop_pixel import bdp_pkg::*; #(
    parameter int unsigned IMAGE_WIDTH  = DefImageWidth,
    parameter int unsigned IMAGE_HEIGHT = DefImageHeight
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // pixel_x[9:0], pixel_y[19:10], zero pad
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // red[7:0], green[15:8], blue[23:16]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam coord_t WidthLast  = CoordW'(IMAGE_WIDTH - 1);
    localparam coord_t HeightLast = CoordW'(IMAGE_HEIGHT - 1);

    rgb_t      corner_tl_reg, corner_bl_reg, corner_tr_reg, corner_br_reg, glow_reg;
    reg_idx_t  reg_idx;
    logic      cfg_write;

    logic [NumStages:1] valid_reg, valid_next;
    stage_en_t          stage_en;

    pix_t  x_raw, y_raw, x1_next, y1_next, x1_reg, y1_reg;
    rgb_t  base7, pixel11;
    chan_t glow7;
    logic [DitherW-1:0] dither7;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign reg_idx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_tl_reg <= RstCornerTl;
            corner_bl_reg <= RstCornerBl;
            corner_tr_reg <= RstCornerTr;
            corner_br_reg <= RstCornerBr;
            glow_reg      <= RstGlow;
        end else if (cfg_write) begin
            case (reg_idx)
                RegCornerTl: corner_tl_reg <= pwdata[23:0];
                RegCornerBl: corner_bl_reg <= pwdata[23:0];
                RegCornerTr: corner_tr_reg <= pwdata[23:0];
                RegCornerBr: corner_br_reg <= pwdata[23:0];
                RegGlow:     glow_reg      <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            RegCornerTl: prdata = {8'd0, corner_tl_reg};
            RegCornerBl: prdata = {8'd0, corner_bl_reg};
            RegCornerTr: prdata = {8'd0, corner_tr_reg};
            RegCornerBr: prdata = {8'd0, corner_br_reg};
            RegGlow:     prdata = {8'd0, glow_reg};
            default:     prdata = '0;
        endcase
    end

    // stage enables: a stage moves when it is empty or the next one moves
    always_comb begin
        stage_en[NumStages] = !valid_reg[NumStages] || m_tready;
        for (int k = NumStages - 1; k >= 1; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k + 1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (stage_en[1]) begin
            valid_next[1] = s_tvalid;
        end
        for (int k = 2; k <= NumStages; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = valid_reg[k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[1];
    assign m_tvalid = valid_reg[NumStages];

    // stage 1: saturate coordinates to the image
    always_comb begin
        x_raw   = s_tdata[PixW-1:0];
        y_raw   = s_tdata[2*PixW-1:PixW];
        x1_next = (CoordW'(x_raw) > WidthLast)  ? WidthLast[PixW-1:0]  : x_raw;
        y1_next = (CoordW'(y_raw) > HeightLast) ? HeightLast[PixW-1:0] : y_raw;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            x1_reg <= x1_next;
            y1_reg <= y1_next;
        end
    end

    bdp_grad #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_grad (
        .aclk      (aclk),
        .stage_en  (stage_en),
        .x_in      (x1_reg),
        .y_in      (y1_reg),
        .corner_tl (corner_tl_reg),
        .corner_bl (corner_bl_reg),
        .corner_tr (corner_tr_reg),
        .corner_br (corner_br_reg),
        .base_out  (base7)
    );

    bdp_glow #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_glow (
        .aclk     (aclk),
        .stage_en (stage_en),
        .x_in     (x1_reg),
        .y_in     (y1_reg),
        .glow_out (glow7)
    );

    bdp_hash u_hash (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .x_in       (x1_reg),
        .y_in       (y1_reg),
        .dither_out (dither7)
    );

    bdp_mix u_mix (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .base_in    (base7),
        .glow_in    (glow7),
        .dither_in  (dither7),
        .glow_color (glow_reg),
        .pixel_out  (pixel11)
    );

    // red in the low byte
    assign m_tdata = {pixel11[0], pixel11[1], pixel11[2]};

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import bdp_pkg::*;

    localparam int unsigned ImgW      = 1024;
    localparam int unsigned ImgH      = 768;
    localparam int unsigned IdleLimit = 4000;
    localparam int unsigned LongHold  = 400;
    localparam int unsigned MaxLines  = 20;

    // register indexes past the list: writes there must change nothing
    localparam logic [2:0] RegSpareLo = 3'd5;
    localparam logic [2:0] RegSpareHi = 3'd7;

    typedef struct packed {
        pix_t y;
        pix_t x;
    } pixel_t;

    typedef struct packed {
        pixel_t pix;
        rgb_t   rgb;
    } pending_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // pixel_x[9:0], pixel_y[19:10], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // red[7:0], green[15:8], blue[23:16]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // pixels waiting to go out, and colors waiting to come back
    pixel_t      pixel_fifo [$];
    pending_t    color_fifo [$];

    // shadow of the color registers
    logic [23:0] tl_color, bl_color, tr_color, br_color, glow_rgb;

    pixel_t      cur_pix;
    int unsigned words_queued   = 0;
    int unsigned words_accepted = 0;
    int unsigned pixels_checked = 0;
    int unsigned clamped_words  = 0;
    int unsigned spare_writes   = 0;
    int unsigned settings       = 0;
    int unsigned mismatches     = 0;
    int unsigned burst_left     = 1;
    int unsigned gap_left       = 0;
    int unsigned hold_requests  = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;
    int unsigned mode_left      = 0;
    int unsigned stall_pct      = 0;

    procedural_backdrop_pixel #(
        .IMAGE_WIDTH (ImgW),
        .IMAGE_HEIGHT(ImgH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // per-channel weighted mix: (a*(t-s) + b*s) / t, truncated
    function automatic rgb_t blend_color(input rgb_t a, input rgb_t b,
                                         input int unsigned s, input int unsigned t);
        rgb_t        mix;
        int unsigned c;
        if (s > t) s = t;
        for (int k = 0; k < 3; k++) begin
            c = (a[k] * (t - s) + b[k] * s) / t;
            mix[k] = c[7:0];
        end
        return mix;
    endfunction

    // low three bits of the multiplicative coordinate hash
    function automatic logic [2:0] dither_weight(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] h;
        h = x * HashMulX + y * HashMulY;
        h = (h ^ (h >> 13)) * HashMulMix;
        h = h ^ (h >> 16);
        return h[2:0];
    endfunction

    function automatic rgb_t predict_pixel(input pixel_t p);
        int unsigned x, y, weight;
        int          dx, dy, rad;
        rgb_t        left_edge, right_edge, base;
        x = p.x;
        y = p.y;
        if (x > ImgW - 1) x = ImgW - 1;
        if (y > ImgH - 1) y = ImgH - 1;
        left_edge  = blend_color(rgb_t'(tl_color), rgb_t'(bl_color), y, ImgH - 1);
        right_edge = blend_color(rgb_t'(tr_color), rgb_t'(br_color), y, ImgH - 1);
        base       = blend_color(left_edge, right_edge, x, ImgW - 1);
        // elliptical glow around (W/2, H/3)
        dx   = int'(x) - int'(ImgW / 2);
        dy   = int'(y) - int'(ImgH / 3);
        rad  = (dx * dx) / 6 + (dy * dy) / 3;
        weight = (rad < int'(GlowLimit)) ? GlowPeak - rad / int'(GlowFalloff) : 0;
        base = blend_color(base, rgb_t'(glow_rgb), weight, FullScale);
        return blend_color(base, rgb_t'(24'hffffff), dither_weight(x, y), FullScale);
    endfunction

    task automatic report_mismatch(input string what, input pixel_t pix,
                                   input chan_t got, input chan_t want);
        mismatches++;
        if (mismatches <= MaxLines)
            $display("%0t mismatch %s at (%0d,%0d): got %02h want %02h",
                     $time, what, pix.x, pix.y, got, want);
    endtask

    task automatic push_pixel(input int unsigned x, input int unsigned y);
        pixel_t p;
        p.x = pix_t'(x);
        p.y = pix_t'(y);
        pixel_fifo.push_back(p);
        words_queued++;
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] rgb);
        logic [7:0] junk;
        junk = 8'($urandom);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, rgb};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_palette(input logic [23:0] tl, input logic [23:0] bl,
                               input logic [23:0] tr, input logic [23:0] br,
                               input logic [23:0] glow);
        write_reg(RegCornerTl, tl);
        write_reg(RegCornerBl, bl);
        write_reg(RegCornerTr, tr);
        write_reg(RegCornerBr, br);
        write_reg(RegGlow, glow);
        settings++;
    endtask

    // wait until every pixel went in and every color came back
    task automatic settle();
        while (words_accepted != words_queued || color_fifo.size() != 0)
            @(posedge aclk);
        repeat (NumStages + 2) @(posedge aclk);
    endtask

    // image corners, clamped coordinates, glow rim on three sides, bit patterns
    task automatic queue_corner_cases();
        push_pixel(0, 0);
        push_pixel(ImgW - 1, 0);
        push_pixel(0, ImgH - 1);
        push_pixel(ImgW - 1, ImgH - 1);
        push_pixel(1023, 1023);
        push_pixel(0, 1023);
        push_pixel(512, 1023);
        push_pixel(768, 800);
        push_pixel(1023, 768);
        push_pixel(512, 256);
        push_pixel(512, 584);
        push_pixel(512, 585);
        push_pixel(976, 256);
        push_pixel(977, 256);
        push_pixel(47, 256);
        push_pixel(48, 256);
        push_pixel(1022, 766);
        push_pixel(1, 1);
        push_pixel(10'h155, 10'h2aa);
        push_pixel(10'h2aa, 10'h155);
    endtask

    // mostly raster runs, some glow-area hits, some scattered points
    task automatic queue_scatter(input int unsigned n);
        int unsigned left, run, x0, y0, kind;
        left = n;
        while (left > 0) begin
            kind = $urandom_range(0, 9);
            y0 = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                             : $urandom_range(0, ImgH - 1);
            if (kind < 5) begin
                x0  = $urandom_range(0, ImgW - 1);
                run = $urandom_range(4, 32);
                for (int i = 0; i < run && left > 0 && x0 + i < ImgW; i++) begin
                    push_pixel(x0 + i, y0);
                    left--;
                end
            end else if (kind < 7) begin
                push_pixel($urandom_range(ImgW / 2 - 480, ImgW / 2 + 480),
                           $urandom_range(0, 620));
                left--;
            end else begin
                push_pixel($urandom_range(0, 1023), y0);
                left--;
            end
        end
    endtask

    // color register shadow
    always @(posedge aclk) begin
        if (!aresetn) begin
            tl_color <= RstCornerTl;
            bl_color <= RstCornerBl;
            tr_color <= RstCornerTr;
            br_color <= RstCornerBr;
            glow_rgb <= RstGlow;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                RegCornerTl: tl_color <= pwdata[23:0];
                RegCornerBl: bl_color <= pwdata[23:0];
                RegCornerTr: tr_color <= pwdata[23:0];
                RegCornerBr: br_color <= pwdata[23:0];
                RegGlow:     glow_rgb <= pwdata[23:0];
                default:     spare_writes++;
            endcase
        end
    end

    // input driver: bursts of words with random gaps
    always @(posedge aclk) begin
        logic offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                color_fifo.push_back('{pix: cur_pix, rgb: predict_pixel(cur_pix)});
                words_accepted++;
                if (cur_pix.x > ImgW - 1 || cur_pix.y > ImgH - 1) clamped_words++;
            end
            if (!s_tvalid || s_tready) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pixel_fifo.size() > 0) begin
                    cur_pix = pixel_fifo.pop_front();
                    offer   = 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                s_tvalid <= offer;
                if (offer) s_tdata <= {4'b0, cur_pix.y, cur_pix.x};
            end
        end
    end

    // output side ready: changing stall density, plus a requested long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = LongHold;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(20, 150);
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    default: stall_pct = 75;
                endcase
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(1, 100) > stall_pct);
            end
        end
    end

    // output checker
    always @(posedge aclk) begin
        pending_t want;
        pixel_t   none;
        if (aresetn && m_tvalid && m_tready) begin
            none = '0;
            if (color_fifo.size() == 0) begin
                report_mismatch("word with no pixel pending", none, m_tdata[7:0], 8'h00);
            end else begin
                want = color_fifo.pop_front();
                pixels_checked++;
                if (m_tdata[7:0] !== want.rgb[2])
                    report_mismatch("red", want.pix, m_tdata[7:0], want.rgb[2]);
                if (m_tdata[15:8] !== want.rgb[1])
                    report_mismatch("green", want.pix, m_tdata[15:8], want.rgb[1]);
                if (m_tdata[23:16] !== want.rgb[0])
                    report_mismatch("blue", want.pix, m_tdata[23:16], want.rgb[0]);
            end
        end
    end

    // watchdog: too long without any word or register access
    initial begin
        int unsigned idle;
        idle = 0;
        while (idle < IdleLimit) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no activity for %0d cycles", IdleLimit);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [23:0] rnd [5];
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset colors
        queue_corner_cases();
        queue_scatter(260);
        settle();

        // all black, then spare addresses written with white
        set_palette(24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
        for (int i = RegSpareLo; i <= RegSpareHi; i++) write_reg(3'(i), 24'hffffff);
        queue_scatter(220);
        settle();

        // all white
        set_palette(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
        queue_corner_cases();
        queue_scatter(220);
        settle();

        // opposite corners; output held off long enough to back up the input
        set_palette(24'hffffff, 24'h000000, 24'h000000, 24'hffffff, 24'h808080);
        hold_requests <= hold_requests + 1;
        queue_scatter(260);
        settle();

        // random colors, input paused in the middle until drained
        for (int i = 0; i < 5; i++) rnd[i] = 24'($urandom);
        set_palette(rnd[0], rnd[1], rnd[2], rnd[3], rnd[4]);
        queue_scatter(200);
        settle();
        queue_scatter(200);
        settle();

        $display("checked %0d pixels under %0d color settings plus reset colors",
                 pixels_checked, settings);
        $display("%0d words with clamped coordinates, %0d writes to spare addresses",
                 clamped_words, spare_writes);
        if (mismatches == 0 && color_fifo.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d pixels outstanding", mismatches, color_fifo.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
